[rtl/ps2sc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2sc_pkg
// Shared types, modifier bit masks, key codes and character tables for the
// scan-code set 1 decoder.
// ----------------------------------------------------------------------------
package ps2sc_pkg;

   // Modifier register layout: b0 shift b1 ctrl b2 alt b3 caps b4 num
   // b5 scroll b6 e0
   typedef logic [6:0] mod_type;

   typedef struct packed {
      logic [7:0] char_code;
      mod_type    flags;
   } result_type;

   localparam mod_type M_NONE   = 7'h00;
   localparam mod_type M_SHIFT  = 7'h01;
   localparam mod_type M_CTRL   = 7'h02;
   localparam mod_type M_ALT    = 7'h04;
   localparam mod_type M_CAPS   = 7'h08;
   localparam mod_type M_NUM    = 7'h10;
   localparam mod_type M_SCROLL = 7'h20;
   localparam mod_type M_E0     = 7'h40;

   localparam logic [7:0] BYTE_E0     = 8'hE0;
   localparam logic [7:0] EXT_FLAG    = 8'h80;
   localparam logic [7:0] CHAR_NONE   = 8'h00;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // Held and lock keys
   localparam logic [7:0] KEY_LCTRL  = 8'h1D;
   localparam logic [7:0] KEY_RCTRL  = 8'h9D;
   localparam logic [7:0] KEY_LSHIFT = 8'h2A;
   localparam logic [7:0] KEY_RSHIFT = 8'h36;
   localparam logic [7:0] KEY_LALT   = 8'h38;
   localparam logic [7:0] KEY_RALT   = 8'hB8;
   localparam logic [7:0] KEY_CAPS   = 8'h3A;
   localparam logic [7:0] KEY_NUM    = 8'h45;
   localparam logic [7:0] KEY_SCROLL = 8'h46;

   // Table depths
   localparam int PLAIN_DEPTH = 84;
   localparam int CTRL_DEPTH  = 56;
   localparam logic [7:0] PLAIN_LEN = 8'(PLAIN_DEPTH);
   localparam logic [7:0] CTRL_LEN  = 8'(CTRL_DEPTH);

   localparam logic [7:0] PLAIN_TAB [0:PLAIN_DEPTH-1] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
      8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E
   };

   localparam logic [7:0] SHIFT_TAB [0:PLAIN_DEPTH-1] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
      8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E
   };

   localparam logic [7:0] CTRL_TAB [0:CTRL_DEPTH-1] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h11, 8'h17, 8'h05, 8'h12, 8'h14, 8'h19, 8'h15, 8'h09,
      8'h0F, 8'h10, 8'h00, 8'h00, 8'h0D, 8'h00, 8'h01, 8'h13,
      8'h04, 8'h06, 8'h07, 8'h08, 8'h0A, 8'h0B, 8'h0C, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h1C, 8'h1A, 8'h18, 8'h03, 8'h16,
      8'h02, 8'h0E, 8'h0D, 8'h00, 8'h00, 8'h1F, 8'h00, 8'h00
   };

   // Modifier held while this key is down
   function automatic mod_type held_bit(input logic [7:0] key);
      case (key)
         KEY_LCTRL, KEY_RCTRL:   held_bit = M_CTRL;
         KEY_LSHIFT, KEY_RSHIFT: held_bit = M_SHIFT;
         KEY_LALT, KEY_RALT:     held_bit = M_ALT;
         default:                held_bit = M_NONE;
      endcase
   endfunction

   // Lock toggled by a press of this key
   function automatic mod_type lock_bit(input logic [7:0] key);
      case (key)
         KEY_CAPS:   lock_bit = M_CAPS;
         KEY_NUM:    lock_bit = M_NUM;
         KEY_SCROLL: lock_bit = M_SCROLL;
         default:    lock_bit = M_NONE;
      endcase
   endfunction

   // Extended keys (E0 prefix): keypad enter/divide and navigation codes
   function automatic logic [7:0] ext_code(input logic [7:0] key, input logic ctrl);
      case (key)
         8'h9C:   ext_code = 8'h0A;
         8'hB5:   ext_code = ctrl ? 8'h1F : 8'h2F;
         8'hC8:   ext_code = 8'hE0;
         8'hD0:   ext_code = 8'hE1;
         8'hCB:   ext_code = 8'hE2;
         8'hCD:   ext_code = 8'hE3;
         8'hC7:   ext_code = 8'hE4;
         8'hCF:   ext_code = 8'hE5;
         8'hC9:   ext_code = 8'hE6;
         8'hD1:   ext_code = 8'hE7;
         8'hD2:   ext_code = 8'hE8;
         8'hD3:   ext_code = 8'hE9;
         default: ext_code = CHAR_NONE;
      endcase
   endfunction

endpackage

[rtl/ps2sc_state_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2sc_state_mem
// Single-entry modifier state memory with a registered (synchronous) read.
// A valid bit stands in for the reset value until first write.
// ----------------------------------------------------------------------------
module ps2sc_state_mem (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic                wr_en,
   input  ps2sc_pkg::mod_type  wr_data,
   output ps2sc_pkg::mod_type  rd_data
);
   import ps2sc_pkg::*;

   mod_type mem_ff [0:0];
   logic    valid_ff;
   mod_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[0] <= wr_data;
      end
   end

   // valid bit: entry reads as zero until first write
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff <= 1'b1;
      end
   end

   // registered read port (old data on a same-cycle write)
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff ? mem_ff[0] : M_NONE;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ps2sc_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2sc_decode
// Modify step: applies one scan byte to the modifier state and looks up the
// character in the plain, shift, ctrl or extended table.
// ----------------------------------------------------------------------------
module ps2sc_decode (
   input  logic                   [7:0] scan_byte,
   input  ps2sc_pkg::mod_type           state_cur,
   output ps2sc_pkg::result_type        result
);
   import ps2sc_pkg::*;

   always_comb begin
      logic [7:0] key;
      mod_type    st;
      logic [7:0] c;

      st  = state_cur;
      c   = CHAR_NONE;
      key = scan_byte;

      if (scan_byte == BYTE_E0) begin
         // escape prefix
         st = st | M_E0;
      end else if (scan_byte[7]) begin
         // release: extended key keeps bit 7
         key = (st & M_E0) != M_NONE ? scan_byte : (scan_byte & ~EXT_FLAG);
         st  = st & ~(held_bit(key) | M_E0);
      end else begin
         // press
         if ((st & M_E0) != M_NONE) begin
            key = scan_byte | EXT_FLAG;
            st  = st & ~M_E0;
         end
         st = st | held_bit(key);
         st = st ^ lock_bit(key);

         // table lookup, ctrl wins over shift
         if (key[7]) begin
            c = ext_code(key, (st & M_CTRL) != M_NONE);
         end else if ((st & M_CTRL) != M_NONE) begin
            c = (key < CTRL_LEN) ? CTRL_TAB[key[5:0]] : CHAR_NONE;
         end else if (key < PLAIN_LEN) begin
            c = ((st & M_SHIFT) != M_NONE) ? SHIFT_TAB[key[6:0]] : PLAIN_TAB[key[6:0]];
         end

         // caps lock swaps letter case
         if ((st & M_CAPS) != M_NONE) begin
            if (c inside {[8'h61:8'h7A]}) begin
               c = c - CASE_OFFSET;
            end else if (c inside {[8'h41:8'h5A]}) begin
               c = c + CASE_OFFSET;
            end
         end
      end

      result.char_code = c;
      result.flags     = st;
   end

endmodule

[rtl/ps2_scancode_to_char.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_scancode_to_char
// Scan-code set 1 decoder: one raw keyboard byte in, one character code and
// the updated modifier flags out per item.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one scan byte per item, rsp_* one character code (0 when
//   nothing is produced) and the modifier flags after that byte. Both are
//   valid/ready channels.
//   A byte accepted on req_* is registered in the decode stage, decoded
//   there combinationally and registered in the result register, which
//   offers it on rsp_*. Throughput: one item per cycle unless rsp_ stalls.
//   The modifier state lives in a one-entry memory with a registered read;
//   the read-modify-write loop through it is closed by forwarding the
//   value written in the same cycle as the read.
//   Reset clears the modifier state (no keys held, locks off, no escape)
//   and empties the pipeline; no clearing pass is needed.
//   When the receiver stalls, the result register holds its item and one
//   more byte waits in the decode stage; req_ready then drops until the
//   result is taken.
// ----------------------------------------------------------------------------
module ps2_scancode_to_char (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_char_code,
   output logic [6:0] rsp_modifier_flags
);
   import ps2sc_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff;
   mod_type    rsp_flags_ff;
   logic       bypass_ff, bypass_in;
   mod_type    bypass_data_ff;

   logic       req_take;
   logic       s1_adv;
   mod_type    mem_rd_data;
   mod_type    state_cur;
   result_type dec_result;

   // handshake
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_take  = req_valid && req_ready;

   // modifier state memory: read on accept, write when the item leaves
   ps2sc_state_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .wr_en   (s1_adv),
      .wr_data (dec_result.flags),
      .rd_data (mem_rd_data)
   );

   // forward the state written in the cycle the read was issued
   assign bypass_in = s1_adv;

   always_ff @(posedge clock) begin
      if (req_take) begin
         bypass_data_ff <= dec_result.flags;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else if (req_take) begin
         bypass_ff <= bypass_in;
      end
   end

   assign state_cur = bypass_ff ? bypass_data_ff : mem_rd_data;

   ps2sc_decode u_dec (
      .scan_byte (s1_byte_ff),
      .state_cur (state_cur),
      .result    (dec_result)
   );

   // decode stage
   assign s1_valid_in = req_take || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_scan_byte;
      end
   end

   // result register
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_char_ff  <= dec_result.char_code;
         rsp_flags_ff <= dec_result.flags;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_char_code      = rsp_char_ff;
   assign rsp_modifier_flags = rsp_flags_ff;

   // checks
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a full pipeline");

   a_escape_sets_e0: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_byte_ff == BYTE_E0) |=> ((rsp_modifier_flags & M_E0) != M_NONE))
      else $error("escape byte did not set e0 flag");

   a_release_no_char: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_byte_ff[7]) |=> (rsp_char_code == CHAR_NONE))
      else $error("release or escape byte produced a character");

   a_fwd_state: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && req_take) |=> (state_cur == $past(dec_result.flags)))
      else $error("next item did not see forwarded modifier state");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scan-code set 1 decoder. Feeds scan bytes
// through the req_ valid/ready channel with bursty pacing, stalls the rsp_
// channel on its own pattern (with one long hold-off), and checks every
// character code and modifier value against typed-in values (fixed rows)
// or a local decoder model that tracks held keys, locks and the E0 escape.
// ----------------------------------------------------------------------------
module tb_top;
   import ps2sc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 630;
   localparam int PLAIN_KEYS   = 84;
   localparam int CTRL_KEYS    = 56;
   localparam int HOLD_AFTER   = 300;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 8;

   // Character tables, indexed by scan code
   localparam logic [7:0] plain_chars [0:PLAIN_KEYS-1] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
      8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E
   };

   localparam logic [7:0] shift_chars [0:PLAIN_KEYS-1] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
      8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E
   };

   localparam logic [7:0] ctrl_chars [0:CTRL_KEYS-1] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h11, 8'h17, 8'h05, 8'h12, 8'h14, 8'h19, 8'h15, 8'h09,
      8'h0F, 8'h10, 8'h00, 8'h00, 8'h0D, 8'h00, 8'h01, 8'h13,
      8'h04, 8'h06, 8'h07, 8'h08, 8'h0A, 8'h0B, 8'h0C, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h1C, 8'h1A, 8'h18, 8'h03, 8'h16,
      8'h02, 8'h0E, 8'h0D, 8'h00, 8'h00, 8'h1F, 8'h00, 8'h00
   };

   // Key groups used to build random typing sequences
   localparam logic [7:0] held_keys [0:3] = '{KEY_LCTRL, KEY_LSHIFT, KEY_RSHIFT, KEY_LALT};
   localparam logic [7:0] lock_keys [0:2] = '{KEY_CAPS, KEY_NUM, KEY_SCROLL};
   localparam logic [7:0] ext_keys [0:11] = '{
      8'h1C, 8'h35, 8'h47, 8'h48, 8'h49, 8'h4B,
      8'h4D, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53
   };

   // Directed rows: fixed = 1 means the expected item is typed in here
   typedef struct packed {
      logic [7:0] scan;
      logic       fixed;
      logic [7:0] ch;
      mod_type    fl;
   } scan_row_type;

   localparam int DIRECTED_ROWS = 28;
   localparam scan_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{8'h00, 1'b1, 8'h00, M_NONE},                     // key with no code
      '{8'h1E, 1'b1, 8'h61, M_NONE},                     // 'a'
      '{8'h2A, 1'b1, 8'h00, M_SHIFT},                    // left shift down
      '{8'h1E, 1'b1, 8'h41, M_SHIFT},                    // 'A'
      '{8'hAA, 1'b1, 8'h00, M_NONE},                     // left shift up
      '{8'h3A, 1'b1, 8'h00, M_CAPS},                     // caps on
      '{8'h1E, 1'b1, 8'h41, M_CAPS},                     // caps swaps 'a'
      '{8'h2A, 1'b1, 8'h00, M_CAPS | M_SHIFT},
      '{8'h1E, 1'b1, 8'h61, M_CAPS | M_SHIFT},           // caps swaps 'A'
      '{8'hAA, 1'b1, 8'h00, M_CAPS},
      '{8'h1D, 1'b1, 8'h00, M_CAPS | M_CTRL},            // ctrl down
      '{8'h35, 1'b1, 8'h1F, M_CAPS | M_CTRL},            // ctrl and slash
      '{8'hE0, 1'b1, 8'h00, M_CAPS | M_CTRL | M_E0},
      '{8'h35, 1'b0, 8'h00, M_NONE},                     // keypad divide, ctrl
      '{8'h9D, 1'b1, 8'h00, M_CAPS},                     // ctrl up
      '{8'hE0, 1'b1, 8'h00, M_CAPS | M_E0},
      '{8'h47, 1'b0, 8'h00, M_NONE},                     // home
      '{8'h38, 1'b1, 8'h00, M_CAPS | M_ALT},             // left alt down
      '{8'hE0, 1'b1, 8'h00, M_CAPS | M_ALT | M_E0},
      '{8'hB8, 1'b1, 8'h00, M_CAPS},                     // extended release of alt
      '{8'h45, 1'b1, 8'h00, M_CAPS | M_NUM},             // num lock
      '{8'h46, 1'b1, 8'h00, M_CAPS | M_NUM | M_SCROLL},  // scroll lock
      '{8'h7F, 1'b1, 8'h00, M_CAPS | M_NUM | M_SCROLL},  // past the table
      '{8'hFF, 1'b1, 8'h00, M_CAPS | M_NUM | M_SCROLL},  // top release byte
      '{8'h01, 1'b1, 8'h1B, M_CAPS | M_NUM | M_SCROLL},  // escape key
      '{8'h3A, 1'b1, 8'h00, M_NUM | M_SCROLL},           // caps off
      '{8'hE0, 1'b1, 8'h00, M_NUM | M_SCROLL | M_E0},
      '{8'h1E, 1'b0, 8'h00, M_NONE}                      // extended key, no code
   };

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_BUSY_LIGHT,
      RX_BUSY_HEAVY,
      RX_EVERY_THIRD
   } rx_mode_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_scan_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_char_code;
   logic [6:0] rsp_modifier_flags;

   mod_type    held_mods = M_NONE;
   result_type pending_chars [$];
   int         chars_taken = 0;
   int         mismatch_count = 0;
   int         cycle_count = 0;
   int         burst_left = 0;

   ps2_scancode_to_char u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_scan_byte      (req_scan_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_char_code      (rsp_char_code),
      .rsp_modifier_flags (rsp_modifier_flags)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Modifier bit held while the given key is down
   function automatic mod_type held_key_mask(input logic [7:0] key);
      case (key)
         KEY_LCTRL, KEY_RCTRL:   return M_CTRL;
         KEY_LSHIFT, KEY_RSHIFT: return M_SHIFT;
         KEY_LALT, KEY_RALT:     return M_ALT;
         default:                return M_NONE;
      endcase
   endfunction

   // Decode one scan byte, advancing the local modifier copy
   function automatic result_type decode_scan(input logic [7:0] b);
      logic [7:0] key;
      logic [7:0] ch;
      result_type r;
      ch  = CHAR_NONE;
      key = b;
      if (b == BYTE_E0) begin
         held_mods = held_mods | M_E0;
      end else if ((b & EXT_FLAG) != 8'h00) begin
         // release: plain keys drop bit 7, extended keys keep it
         if ((held_mods & M_E0) == M_NONE)
            key = b & ~EXT_FLAG;
         held_mods = held_mods & ~(held_key_mask(key) | M_E0);
      end else begin
         if ((held_mods & M_E0) != M_NONE)
            key = b | EXT_FLAG;
         held_mods = (held_mods & ~M_E0) | held_key_mask(key);
         case (key)
            KEY_CAPS:   held_mods = held_mods ^ M_CAPS;
            KEY_NUM:    held_mods = held_mods ^ M_NUM;
            KEY_SCROLL: held_mods = held_mods ^ M_SCROLL;
            default:    ;
         endcase
         // lookup with the updated modifiers; ctrl beats shift
         if ((key & EXT_FLAG) != 8'h00) begin
            case (key)
               8'h9C: ch = 8'h0A;                                            // keypad enter
               8'hB5: ch = ((held_mods & M_CTRL) != M_NONE) ? 8'h1F : 8'h2F; // keypad divide
               8'hC8: ch = 8'hE0;   // up
               8'hD0: ch = 8'hE1;   // down
               8'hCB: ch = 8'hE2;   // left
               8'hCD: ch = 8'hE3;   // right
               8'hC7: ch = 8'hE4;   // home
               8'hCF: ch = 8'hE5;   // end
               8'hC9: ch = 8'hE6;   // page up
               8'hD1: ch = 8'hE7;   // page down
               8'hD2: ch = 8'hE8;   // insert
               8'hD3: ch = 8'hE9;   // delete
               default: ch = CHAR_NONE;
            endcase
         end else if ((held_mods & M_CTRL) != M_NONE) begin
            if (key < CTRL_KEYS)
               ch = ctrl_chars[key[5:0]];
         end else if (key < PLAIN_KEYS) begin
            ch = ((held_mods & M_SHIFT) != M_NONE) ? shift_chars[key[6:0]]
                                                    : plain_chars[key[6:0]];
         end
         // caps lock swaps letter case
         if ((held_mods & M_CAPS) != M_NONE) begin
            if (ch >= 8'h61 && ch <= 8'h7A)
               ch = ch - CASE_OFFSET;
            else if (ch >= 8'h41 && ch <= 8'h5A)
               ch = ch + CASE_OFFSET;
         end
      end
      r.char_code = ch;
      r.flags     = held_mods;
      return r;
   endfunction

   // Offer one byte with burst pacing; predict on acceptance
   task automatic offer_byte(input logic [7:0] b, input logic fixed, input result_type typed_in);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_scan_byte <= b;
      do @(posedge clock); while (!req_ready);
      if (fixed) begin
         void'(decode_scan(b));
         pending_chars.push_back(typed_in);
      end else begin
         pending_chars.push_back(decode_scan(b));
      end
      @(negedge clock);
   endtask

   // Stimulus: directed rows, then random typing
   initial begin : drive_req
      logic [7:0] scan_q [$];
      logic [7:0] b;
      result_type typed_in;
      int pick;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_scan_byte = 8'h00;

      while (scan_q.size() < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            // ordinary key, often followed by its release
            b = 8'($urandom_range(1, 8'h53));
            scan_q.push_back(b);
            if ($urandom_range(0, 1) == 1)
               scan_q.push_back(b | EXT_FLAG);
         end else if (pick < 52) begin
            b = held_keys[$urandom_range(0, 3)];
            if ($urandom_range(0, 2) == 0)
               scan_q.push_back(BYTE_E0);
            scan_q.push_back(b);
         end else if (pick < 64) begin
            b = held_keys[$urandom_range(0, 3)];
            if ($urandom_range(0, 2) == 0)
               scan_q.push_back(BYTE_E0);
            scan_q.push_back(b | EXT_FLAG);
         end else if (pick < 68) begin
            b = lock_keys[$urandom_range(0, 2)];
            scan_q.push_back(b);
            scan_q.push_back(b | EXT_FLAG);
         end else if (pick < 83) begin
            // extended navigation / keypad key
            b = ext_keys[$urandom_range(0, 11)];
            scan_q.push_back(BYTE_E0);
            scan_q.push_back(b);
            if ($urandom_range(0, 1) == 1) begin
               scan_q.push_back(BYTE_E0);
               scan_q.push_back(b | EXT_FLAG);
            end
         end else if (pick < 93) begin
            scan_q.push_back(BYTE_E0);
            scan_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            scan_q.push_back(8'($urandom_range(0, 255)));
         end
      end

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         typed_in.char_code = directed_rows[i].ch;
         typed_in.flags     = directed_rows[i].fl;
         offer_byte(directed_rows[i].scan, directed_rows[i].fixed, typed_in);
      end
      typed_in = '0;
      foreach (scan_q[i])
         offer_byte(scan_q[i], 1'b0, typed_in);
      req_valid <= 1'b0;

      // drain, then settle
      while (pending_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Receiver stall pattern, plus one long hold-off to back up the input
   initial begin : drive_rsp
      rx_mode_type mode;
      int left;
      bit held_off;
      rsp_ready = 1'b0;
      mode      = RX_OPEN;
      left      = 0;
      held_off  = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && chars_taken >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            if (left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
               RX_OPEN:       rsp_ready <= 1'b1;
               RX_BUSY_LIGHT: rsp_ready <= ($urandom_range(0, 9) < 7);
               RX_BUSY_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:       rsp_ready <= (left % 3 == 0);
            endcase
         end
      end
   end

   // Compare each accepted item with the oldest prediction
   always @(posedge clock) begin : check_rsp
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected item: char %h flags %h", $time,
                     rsp_char_code, rsp_modifier_flags);
            mismatch_count++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_char_code !== want.char_code) begin
               $display("%0t: char_code expected %h actual %h", $time,
                        want.char_code, rsp_char_code);
               mismatch_count++;
            end
            if (rsp_modifier_flags !== want.flags) begin
               $display("%0t: modifier_flags expected %h actual %h", $time,
                        want.flags, rsp_modifier_flags);
               mismatch_count++;
            end
         end
         chars_taken++;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule

[files.f]
rtl/ps2sc_pkg.sv
rtl/ps2sc_state_mem.sv
rtl/ps2sc_decode.sv
rtl/ps2_scancode_to_char.sv
test/tb_top.sv
